// ===== sv/fptl_pkg.sv =====
// ----------------------------------------------------------------------------
// fptl_pkg
// Shared types and constants for the field permission table lookup unit.
// ----------------------------------------------------------------------------
package fptl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH  = 4096;
    localparam int RULE_AW      = $clog2(TABLE_DEPTH);
    localparam int MAX_MESSAGES = 256;
    localparam int OFS_DEPTH    = MAX_MESSAGES + 1;
    localparam int OFS_AW       = $clog2(OFS_DEPTH);

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int ENTRY_W  = 12;
    localparam int WORD_W   = 32;
    localparam int MSG_W    = 8;
    localparam int FIELD_W  = 29;
    localparam int NEST_W   = 31;
    localparam int COUNT_W  = 9;
    localparam int OFS_W    = 13;

    // Walk pointer: offset plus a full header count, plus headroom for steps
    localparam int PTR_W = WORD_W + 2;

    // Request codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_WR_RULE = 2'd0,
        OP_WR_OFS  = 2'd1,
        OP_QUERY   = 2'd2
    } opcode_t;

endpackage

// ===== sv/field_permission_table_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// field_permission_table_lookup_unit
// Per-message field permission lookup over a rule table and an offset table.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ----------------------------------------------
//  request   start, busy          opcode, entry_address, write_data,
//                                 message_index, field_number
//  result    done (1-cycle)       allowed, nested_index
//  config    cfg_write            cfg_data (message count)
//
//  Writes and unknown-message queries never raise busy.
//  A direct hit keeps busy high through S_START, S_HDR and S_FINAL, then shows done:
//  two offset reads and two dependent rule reads through one read port each.
//  A range walk adds an S_LO and an S_HI state per triple scanned (lo and hi read in turn).
//  Reset clears the sequencer and message count; table contents are
//  undefined until written. The receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
module field_permission_table_lookup_unit
    import fptl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [ENTRY_W-1:0]  entry_address,
    input  logic [WORD_W-1:0]   write_data,
    input  logic [MSG_W-1:0]    message_index,
    input  logic [FIELD_W-1:0]  field_number,
    output logic                done,
    output logic                allowed,
    output logic [NEST_W-1:0]   nested_index,
    input  logic                cfg_write,
    input  logic [COUNT_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_HDR,
        S_LO,
        S_HI,
        S_FINAL
    } state_t;

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic                allowed_reg, allowed_next;
    logic [NEST_W-1:0]   nested_reg, nested_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [MSG_W-1:0]    msg_reg, msg_next;
    logic [FIELD_W-1:0]  field_reg, field_next;
    logic [OFS_W-1:0]    start_reg, start_next;
    logic [OFS_W-1:0]    end_reg, end_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [WORD_W-1:0]   lo_reg, lo_next;
    logic                rd_ok_reg, rd_ok_next;

    // Memories and their registered read data
    logic [WORD_W-1:0]   rule_mem [TABLE_DEPTH];
    logic [OFS_W-1:0]    ofs_mem  [OFS_DEPTH];
    logic [WORD_W-1:0]   rule_rd_reg;
    logic [OFS_W-1:0]    ofs_rd_reg;

    logic                accept;
    logic                rule_we;
    logic                ofs_we;
    logic [PTR_W-1:0]    rd_addr;
    logic [OFS_AW-1:0]   ofs_rd_addr;
    logic [WORD_W-1:0]   rule_word;
    logic [PTR_W-1:0]    walk_ptr;
    logic [PTR_W-1:0]    step_ptr;

    assign accept  = start && (state_reg == S_IDLE);
    assign rule_we = accept && (opcode == OP_WR_RULE);
    assign ofs_we  = accept && (opcode == OP_WR_OFS)
                     && (entry_address <= ENTRY_W'(MAX_MESSAGES));

    // Reads past the end of the rule table return zero
    assign rule_word = rd_ok_reg ? rule_rd_reg : '0;

    // Next walk pointers: first triple after the header, and the following triple
    assign walk_ptr = PTR_W'(start_reg) + PTR_W'(1) + PTR_W'(rule_word);
    assign step_ptr = ptr_reg + PTR_W'(3);

    // Rule table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_mem[entry_address[RULE_AW-1:0]] <= write_data;
        end
        rule_rd_reg <= rule_mem[rd_addr[RULE_AW-1:0]];
    end

    // Offset table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ofs_we)
        begin
            ofs_mem[entry_address[OFS_AW-1:0]] <= write_data[OFS_W-1:0];
        end
        ofs_rd_reg <= ofs_mem[ofs_rd_addr];
    end

    // Sequence one request through the shared read ports
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        allowed_next = allowed_reg;
        nested_next  = nested_reg;
        msg_next     = msg_reg;
        field_next   = field_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        ptr_next     = ptr_reg;
        lo_next      = lo_reg;
        rd_addr      = '0;
        ofs_rd_addr  = OFS_AW'(message_index);

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == OP_QUERY))
                begin
                    msg_next   = message_index;
                    field_next = field_number;
                    if (COUNT_W'(message_index) >= count_reg)
                    begin
                        // Unknown message: answer not allowed at once
                        done_next    = 1'b1;
                        allowed_next = 1'b0;
                        nested_next  = '0;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                // Start offset arrived: fetch header and end offset
                start_next  = ofs_rd_reg;
                rd_addr     = PTR_W'(ofs_rd_reg);
                ofs_rd_addr = OFS_AW'(msg_reg) + OFS_AW'(1);
                state_next  = S_HDR;
            end
            S_HDR:
            begin
                end_next = ofs_rd_reg;
                if (WORD_W'(field_reg) < rule_word)
                begin
                    // Direct entry
                    rd_addr    = PTR_W'(start_reg) + PTR_W'(1) + PTR_W'(field_reg);
                    state_next = S_FINAL;
                end
                else if ((walk_ptr + PTR_W'(2)) < PTR_W'(ofs_rd_reg))
                begin
                    ptr_next   = walk_ptr;
                    rd_addr    = walk_ptr;
                    state_next = S_LO;
                end
                else
                begin
                    done_next    = 1'b1;
                    allowed_next = 1'b0;
                    nested_next  = '0;
                    state_next   = S_IDLE;
                end
            end
            S_LO:
            begin
                lo_next    = rule_word;
                rd_addr    = ptr_reg + PTR_W'(1);
                state_next = S_HI;
            end
            S_HI:
            begin
                if ((WORD_W'(field_reg) >= lo_reg) && (WORD_W'(field_reg) < rule_word))
                begin
                    // Range hit: fetch its state word
                    rd_addr    = ptr_reg + PTR_W'(2);
                    state_next = S_FINAL;
                end
                else if ((step_ptr + PTR_W'(2)) < PTR_W'(end_reg))
                begin
                    ptr_next   = step_ptr;
                    rd_addr    = step_ptr;
                    state_next = S_LO;
                end
                else
                begin
                    done_next    = 1'b1;
                    allowed_next = 1'b0;
                    nested_next  = '0;
                    state_next   = S_IDLE;
                end
            end
            S_FINAL:
            begin
                done_next    = 1'b1;
                allowed_next = rule_word[WORD_W-1];
                nested_next  = rule_word[NEST_W-1:0];
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_ok_next = (rd_addr >> RULE_AW) == '0;
    end

    // Hold state, control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            allowed_reg <= 1'b0;
            nested_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            allowed_reg <= allowed_next;
            nested_reg  <= nested_next;
            if (cfg_write)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        msg_reg     <= msg_next;
        field_reg   <= field_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        ptr_reg     <= ptr_next;
        lo_reg      <= lo_next;
        rd_ok_reg   <= rd_ok_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign allowed      = allowed_reg;
    assign nested_index = nested_reg;

endmodule

// ===== sv/fptl_checker.sv =====
// ----------------------------------------------------------------------------
// fptl_checker
// Port-level checks for the field permission table lookup unit.
// ----------------------------------------------------------------------------
module fptl_checker
    import fptl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [OPCODE_W-1:0] opcode,
    input logic                done
);

    // A result never overlaps an active lookup
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // Writes and unused codes produce no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode != OP_QUERY)) |=> !done)
        else $error("result after non-query request");

    // Busy only rises after an accepted query
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && ($past(opcode) == OP_QUERY)))
        else $error("busy without a query");

    // Leaving busy always delivers a result
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("lookup ended without result");

endmodule

bind field_permission_table_lookup_unit fptl_checker u_fptl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .opcode (opcode),
    .done   (done)
);
